// ===== hdl/ray_block_diagonal_hit_test_assert.svh =====
// Assertion macros for the diagonal hit test block.
`ifndef RAY_BLOCK_DIAGONAL_HIT_TEST_ASSERT_SVH
`define RAY_BLOCK_DIAGONAL_HIT_TEST_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define RBDHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBDHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rbdht_pkg.sv =====
package rbdht_pkg;

    localparam int Q_W       = 32;
    localparam int Q_FRAC    = 16;
    localparam int Q_HALF    = 32768;
    localparam int CELL_W    = 15;
    localparam int NUM_W     = 66;
    localparam int DEN_W     = 34;
    localparam int DIV_STEPS = 2;

    localparam logic [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic                     valid;
        logic signed [CELL_W-1:0] cx;
        logic signed [CELL_W-1:0] cy;
        logic                     zero_a;
        logic                     zero_b;
    } t_side;

endpackage

// ===== hdl/rbdht_front.sv =====
module rbdht_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [rbdht_pkg::CELL_W-1:0]    i_cell_x,
    input  logic signed [rbdht_pkg::CELL_W-1:0]    i_cell_y,
    input  logic signed [rbdht_pkg::Q_W-1:0]       i_near_px,
    input  logic signed [rbdht_pkg::Q_W-1:0]       i_near_py,
    input  logic signed [rbdht_pkg::Q_W-1:0]       i_far_px,
    input  logic signed [rbdht_pkg::Q_W-1:0]       i_far_py,
    output logic signed [rbdht_pkg::NUM_W-1:0]     o_num_ax,
    output logic signed [rbdht_pkg::NUM_W-1:0]     o_num_ay,
    output logic signed [rbdht_pkg::NUM_W-1:0]     o_num_bx,
    output logic signed [rbdht_pkg::NUM_W-1:0]     o_num_by,
    output logic signed [rbdht_pkg::DEN_W-1:0]     o_den_a,
    output logic signed [rbdht_pkg::DEN_W-1:0]     o_den_b,
    output rbdht_pkg::t_side                       o_side
);

    localparam int QW    = rbdht_pkg::Q_W;
    localparam int CW    = rbdht_pkg::CELL_W;
    localparam int NW    = rbdht_pkg::NUM_W;
    localparam int DW    = rbdht_pkg::DEN_W;
    localparam int PT_W  = 2 * QW;
    localparam int DD_W  = PT_W + 1;
    localparam int DIF_W = QW + 1;
    localparam int CA_W  = CW + 1;
    localparam int CB_W  = CW + 2;
    localparam int TA_W  = DIF_W + CA_W;
    localparam int TB_W  = DIF_W + CB_W;

    // stage 1: products and differences
    logic                    r_v1;
    logic signed [CW-1:0]    r_cx1, r_cy1;
    logic signed [PT_W-1:0]  r_p1, r_p2, n_p1, n_p2;
    logic signed [DIF_W-1:0] r_ddx, r_ddy, n_ddx, n_ddy;
    logic signed [CA_W-1:0]  r_ca, n_ca;
    logic signed [CB_W-1:0]  r_cb, n_cb;

    // stage 2: cross term, diagonal terms, denominators
    logic                    r_v2;
    logic signed [CW-1:0]    r_cx2, r_cy2;
    logic signed [DD_W-1:0]  r_dd, n_dd;
    logic signed [TA_W-1:0]  r_tax, r_tay, n_tax, n_tay;
    logic signed [TB_W-1:0]  r_tbx, r_tby, n_tbx, n_tby;
    logic signed [DW-1:0]    r_dena, r_denb, n_dena, n_denb;

    // stage 3: numerators
    logic signed [NW-1:0]    r_nax, r_nay, r_nbx, r_nby;
    logic signed [NW-1:0]    n_nax, n_nay, n_nbx, n_nby;
    logic signed [DW-1:0]    r_den_a, r_den_b;
    rbdht_pkg::t_side        r_side, n_side;

    always_comb begin
        n_p1  = i_near_px * i_far_py;
        n_p2  = i_near_py * i_far_px;
        n_ddx = DIF_W'(i_near_px) - DIF_W'(i_far_px);
        n_ddy = DIF_W'(i_near_py) - DIF_W'(i_far_py);
        n_ca  = CA_W'(i_cell_x) - CA_W'(i_cell_y);
        n_cb  = -(CB_W'(i_cell_x) + CB_W'(i_cell_y));
    end

    always_comb begin
        n_dd   = DD_W'(r_p1) - DD_W'(r_p2);
        n_tax  = r_ddx * r_ca;
        n_tay  = r_ddy * r_ca;
        n_tbx  = r_ddx * r_cb;
        n_tby  = r_ddy * r_cb;
        n_dena = DW'(r_ddy) - DW'(r_ddx);
        n_denb = DW'(r_ddx) + DW'(r_ddy);
    end

    always_comb begin
        n_nax = -NW'(r_dd) - (NW'(r_tax) <<< rbdht_pkg::Q_FRAC);
        n_nay = -NW'(r_dd) - (NW'(r_tay) <<< rbdht_pkg::Q_FRAC);
        n_nbx = -NW'(r_dd) - (NW'(r_tbx) <<< rbdht_pkg::Q_FRAC);
        n_nby =  NW'(r_dd) - (NW'(r_tby) <<< rbdht_pkg::Q_FRAC);
        n_side.valid  = r_v2;
        n_side.cx     = r_cx2;
        n_side.cy     = r_cy2;
        n_side.zero_a = (r_dena == '0);
        n_side.zero_b = (r_denb == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_side.valid <= 1'b0;
        end else begin
            r_v1   <= i_valid;
            r_v2   <= r_v1;
            r_side <= n_side;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx1   <= i_cell_x;
        r_cy1   <= i_cell_y;
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_ddx   <= n_ddx;
        r_ddy   <= n_ddy;
        r_ca    <= n_ca;
        r_cb    <= n_cb;
        r_cx2   <= r_cx1;
        r_cy2   <= r_cy1;
        r_dd    <= n_dd;
        r_tax   <= n_tax;
        r_tay   <= n_tay;
        r_tbx   <= n_tbx;
        r_tby   <= n_tby;
        r_dena  <= n_dena;
        r_denb  <= n_denb;
        r_nax   <= n_nax;
        r_nay   <= n_nay;
        r_nbx   <= n_nbx;
        r_nby   <= n_nby;
        r_den_a <= r_dena;
        r_den_b <= r_denb;
    end

    assign o_num_ax = r_nax;
    assign o_num_ay = r_nay;
    assign o_num_bx = r_nbx;
    assign o_num_by = r_nby;
    assign o_den_a  = r_den_a;
    assign o_den_b  = r_den_b;
    assign o_side   = r_side;

endmodule

// ===== hdl/rbdht_div.sv =====
module rbdht_div #(
    parameter int STEPS = rbdht_pkg::DIV_STEPS
) (
    input  logic                               i_clk,
    input  logic signed [rbdht_pkg::NUM_W-1:0] i_num,
    input  logic signed [rbdht_pkg::DEN_W-1:0] i_den,
    output logic signed [rbdht_pkg::Q_W-1:0]   o_quo
);

    localparam int QW    = rbdht_pkg::Q_W;
    localparam int NW    = rbdht_pkg::NUM_W;
    localparam int DW    = rbdht_pkg::DEN_W;
    localparam int HI_W  = NW - QW;
    localparam int CMP_W = (HI_W > DW) ? HI_W : DW;
    localparam int NSTG  = QW / STEPS;

    logic [NW-1:0] r_mag, n_mag;
    logic [DW-1:0] r_dmag, n_dmag;
    logic          r_neg0;

    logic [DW-1:0] r_rem [0:NSTG-1];
    logic [DW-1:0] r_d   [0:NSTG-1];
    logic [QW-1:0] r_lq  [0:NSTG];
    logic          r_neg [0:NSTG];
    logic          r_big [0:NSTG];

    logic [DW-1:0] n_rem [0:NSTG-1];
    logic [QW-1:0] n_lq  [0:NSTG-1];

    logic [QW-1:0] r_quo, n_quo;

    always_comb begin
        n_mag  = i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
        n_dmag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    end

    // restoring division, STEPS quotient bits per stage; lq shifts out
    // dividend bits and shifts in quotient bits
    always_comb begin
        logic [DW-1:0] v_rem;
        logic [QW-1:0] v_lq;
        logic [DW:0]   v_t;
        v_rem = '0;
        v_lq  = '0;
        v_t   = '0;
        for (int s = 0; s < NSTG; s++) begin
            v_rem = r_rem[s];
            v_lq  = r_lq[s];
            for (int k = 0; k < STEPS; k++) begin
                v_t = {v_rem, v_lq[QW-1]};
                if (v_t >= {1'b0, r_d[s]}) begin
                    v_rem = DW'(v_t - {1'b0, r_d[s]});
                    v_lq  = {v_lq[QW-2:0], 1'b1};
                end else begin
                    v_rem = DW'(v_t);
                    v_lq  = {v_lq[QW-2:0], 1'b0};
                end
            end
            n_rem[s] = v_rem;
            n_lq[s]  = v_lq;
        end
    end

    always_comb begin
        if (r_neg[NSTG]) begin
            if (r_big[NSTG] || r_lq[NSTG] > rbdht_pkg::Q_MIN) begin
                n_quo = rbdht_pkg::Q_MIN;
            end else begin
                n_quo = -r_lq[NSTG];
            end
        end else begin
            if (r_big[NSTG] || r_lq[NSTG][QW-1]) begin
                n_quo = rbdht_pkg::Q_MAX;
            end else begin
                n_quo = r_lq[NSTG];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag    <= n_mag;
        r_dmag   <= n_dmag;
        r_neg0   <= i_num[NW-1] ^ i_den[DW-1];
        // quotient of 2^32 or more saturates
        r_big[0] <= CMP_W'(r_mag[NW-1:QW]) >= CMP_W'(r_dmag);
        r_rem[0] <= DW'(r_mag[NW-1:QW]);
        r_lq[0]  <= r_mag[QW-1:0];
        r_d[0]   <= r_dmag;
        r_neg[0] <= r_neg0;
        for (int s = 0; s < NSTG; s++) begin
            r_lq[s+1]  <= n_lq[s];
            r_neg[s+1] <= r_neg[s];
            r_big[s+1] <= r_big[s];
        end
        for (int s = 0; s < NSTG - 1; s++) begin
            r_rem[s+1] <= n_rem[s];
            r_d[s+1]   <= r_d[s];
        end
        r_quo <= n_quo;
    end

    assign o_quo = r_quo;

endmodule

// ===== hdl/rbdht_back.sv =====
module rbdht_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rbdht_pkg::t_side                 i_side,
    input  logic signed [rbdht_pkg::Q_W-1:0] i_ax,
    input  logic signed [rbdht_pkg::Q_W-1:0] i_ay,
    input  logic signed [rbdht_pkg::Q_W-1:0] i_bx,
    input  logic signed [rbdht_pkg::Q_W-1:0] i_by,
    output logic                             o_valid,
    output logic                             o_hit,
    output logic signed [rbdht_pkg::Q_W-1:0] o_hit_x,
    output logic signed [rbdht_pkg::Q_W-1:0] o_hit_y
);

    localparam int QW     = rbdht_pkg::Q_W;
    localparam int EDGE_W = QW + 2;
    localparam logic signed [EDGE_W-1:0] HALF = EDGE_W'(rbdht_pkg::Q_HALF);

    logic                 r_valid, r_hit, n_hit;
    logic signed [QW-1:0] r_x, r_y, n_x, n_y;
    logic                 w_in_a, w_in_b;

    function automatic logic f_in_cell(
        input logic signed [QW-1:0]               px,
        input logic signed [QW-1:0]               py,
        input logic signed [rbdht_pkg::CELL_W-1:0] cx,
        input logic signed [rbdht_pkg::CELL_W-1:0] cy
    );
        logic signed [EDGE_W-1:0] ex, ey, vx, vy;
        ex = EDGE_W'(cx) <<< rbdht_pkg::Q_FRAC;
        ey = EDGE_W'(cy) <<< rbdht_pkg::Q_FRAC;
        vx = EDGE_W'(px);
        vy = EDGE_W'(py);
        return (vx > ex - HALF) && (vx < ex + HALF) && (vy > ey - HALF) && (vy < ey + HALF);
    endfunction

    always_comb begin
        w_in_a = !i_side.zero_a && f_in_cell(i_ax, i_ay, i_side.cx, i_side.cy);
        w_in_b = f_in_cell(i_bx, i_by, i_side.cx, i_side.cy);
        if (w_in_a) begin
            n_hit = 1'b1;
            n_x   = i_ax;
            n_y   = i_ay;
        end else if (i_side.zero_b) begin
            n_hit = 1'b0;
            n_x   = '0;
            n_y   = '0;
        end else begin
            n_hit = w_in_b;
            n_x   = i_bx;
            n_y   = i_by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= i_side.valid;
            r_hit   <= i_side.valid && n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_hit_x = r_x;
    assign o_hit_y = r_y;

endmodule

// ===== hdl/ray_block_diagonal_hit_test.sv =====
// Ray segment against grid cell diagonals, signed Q16.16. One request may be
// issued on every clock cycle while busy is low; busy is high during reset
// and falls once its register has sampled i_rst_n high. Each request
// returns exactly one result, strobed by o_valid for one cycle, in request
// order. Most of the depth lies in the pipelined restoring dividers, which
// retire DIV_STEPS quotient bits per stage; both diagonals are divided side
// by side. Results cannot be held off, so the receiver must take every strobe.
module ray_block_diagonal_hit_test #(
    parameter int DIV_STEPS = rbdht_pkg::DIV_STEPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [rbdht_pkg::CELL_W-1:0] i_cell_x,
    input  logic signed [rbdht_pkg::CELL_W-1:0] i_cell_y,
    input  logic signed [rbdht_pkg::Q_W-1:0]    i_near_px,
    input  logic signed [rbdht_pkg::Q_W-1:0]    i_near_py,
    input  logic signed [rbdht_pkg::Q_W-1:0]    i_far_px,
    input  logic signed [rbdht_pkg::Q_W-1:0]    i_far_py,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic signed [rbdht_pkg::Q_W-1:0]    o_hit_x,
    output logic signed [rbdht_pkg::Q_W-1:0]    o_hit_y
);

    localparam int DIV_LAT  = rbdht_pkg::Q_W / DIV_STEPS + 3;
    localparam int PIPE_LAT = 3 + DIV_LAT + 1;

    logic                                r_busy;
    logic                                w_req;
    logic signed [rbdht_pkg::NUM_W-1:0]  w_num_ax, w_num_ay, w_num_bx, w_num_by;
    logic signed [rbdht_pkg::DEN_W-1:0]  w_den_a, w_den_b;
    logic signed [rbdht_pkg::Q_W-1:0]    w_ax, w_ay, w_bx, w_by;
    rbdht_pkg::t_side                    w_side;
    rbdht_pkg::t_side                    r_side [0:DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy  = r_busy;
    assign w_req = start && !r_busy;

    rbdht_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_req),
        .i_cell_x  (i_cell_x),
        .i_cell_y  (i_cell_y),
        .i_near_px (i_near_px),
        .i_near_py (i_near_py),
        .i_far_px  (i_far_px),
        .i_far_py  (i_far_py),
        .o_num_ax  (w_num_ax),
        .o_num_ay  (w_num_ay),
        .o_num_bx  (w_num_bx),
        .o_num_by  (w_num_by),
        .o_den_a   (w_den_a),
        .o_den_b   (w_den_b),
        .o_side    (w_side)
    );

    rbdht_div #(.STEPS(DIV_STEPS)) u_div_ax (
        .i_clk (i_clk), .i_num (w_num_ax), .i_den (w_den_a), .o_quo (w_ax)
    );
    rbdht_div #(.STEPS(DIV_STEPS)) u_div_ay (
        .i_clk (i_clk), .i_num (w_num_ay), .i_den (w_den_a), .o_quo (w_ay)
    );
    rbdht_div #(.STEPS(DIV_STEPS)) u_div_bx (
        .i_clk (i_clk), .i_num (w_num_bx), .i_den (w_den_b), .o_quo (w_bx)
    );
    rbdht_div #(.STEPS(DIV_STEPS)) u_div_by (
        .i_clk (i_clk), .i_num (w_num_by), .i_den (w_den_b), .o_quo (w_by)
    );

    // side data follows the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_LAT; i++) begin
                r_side[i].valid <= 1'b0;
            end
        end else begin
            r_side[0] <= w_side;
            for (int i = 1; i < DIV_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    rbdht_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side[DIV_LAT-1]),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_valid (o_valid),
        .o_hit   (o_hit),
        .o_hit_x (o_hit_x),
        .o_hit_y (o_hit_y)
    );

`include "ray_block_diagonal_hit_test_assert.svh"

    `RBDHT_ASSERT_IMP(a_result_has_request, i_clk, i_rst_n, o_valid, $past(start && !busy, PIPE_LAT), "result strobe without matching request")
    `RBDHT_ASSERT_IMP(a_hit_only_on_strobe, i_clk, i_rst_n, o_hit, o_valid, "hit flag outside result strobe")
    `RBDHT_ASSERT_NXT(a_busy_reset_only, i_clk, i_rst_n, i_rst_n, !busy, "busy high outside reset")

endmodule

// ===== verif/ray_block_diagonal_hit_test_tb.sv =====
module ray_block_diagonal_hit_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int Q_ONE        = 65536;
    localparam logic RISING     = 1'b1;
    localparam logic FALLING    = 1'b0;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [rbdht_pkg::CELL_W-1:0] cx;
        logic signed [rbdht_pkg::CELL_W-1:0] cy;
        logic signed [rbdht_pkg::Q_W-1:0]    nx;
        logic signed [rbdht_pkg::Q_W-1:0]    ny;
        logic signed [rbdht_pkg::Q_W-1:0]    fx;
        logic signed [rbdht_pkg::Q_W-1:0]    fy;
    } t_ray;

    typedef struct packed {
        logic                             hit;
        logic signed [rbdht_pkg::Q_W-1:0] x;
        logic signed [rbdht_pkg::Q_W-1:0] y;
    } t_cell_hit;

    logic                                i_clk;
    logic                                i_rst_n   = 1'b0;
    logic                                start     = 1'b0;
    logic                                busy;
    logic signed [rbdht_pkg::CELL_W-1:0] i_cell_x  = '0;
    logic signed [rbdht_pkg::CELL_W-1:0] i_cell_y  = '0;
    logic signed [rbdht_pkg::Q_W-1:0]    i_near_px = '0;
    logic signed [rbdht_pkg::Q_W-1:0]    i_near_py = '0;
    logic signed [rbdht_pkg::Q_W-1:0]    i_far_px  = '0;
    logic signed [rbdht_pkg::Q_W-1:0]    i_far_py  = '0;
    logic                                o_valid;
    logic                                o_hit;
    logic signed [rbdht_pkg::Q_W-1:0]    o_hit_x;
    logic signed [rbdht_pkg::Q_W-1:0]    o_hit_y;

    t_cell_hit diagonal_hit_q[$];
    int        mismatch_count = 0;
    int        cycle_count    = 0;
    int        idle_pct       = 0;

    ray_block_diagonal_hit_test dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cell_x  (i_cell_x),
        .i_cell_y  (i_cell_y),
        .i_near_px (i_near_px),
        .i_near_py (i_near_py),
        .i_far_px  (i_far_px),
        .i_far_py  (i_far_py),
        .o_valid   (o_valid),
        .o_hit     (o_hit),
        .o_hit_x   (o_hit_x),
        .o_hit_y   (o_hit_y)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Truncating divide, clamped to Q16.16.
    function automatic logic signed [rbdht_pkg::Q_W-1:0] sat_quotient(
        input t_wide num,
        input t_wide den
    );
        t_wide q;
        t_wide hi_lim;
        t_wide lo_lim;
        q      = num / den;
        hi_lim = $signed(rbdht_pkg::Q_MAX);
        lo_lim = $signed(rbdht_pkg::Q_MIN);
        if (q > hi_lim)
            return rbdht_pkg::Q_MAX;
        if (q < lo_lim)
            return rbdht_pkg::Q_MIN;
        return q[rbdht_pkg::Q_W-1:0];
    endfunction

    function automatic logic try_diagonal(input logic diag, input t_ray r,
                                          output logic signed [rbdht_pkg::Q_W-1:0] px,
                                          output logic signed [rbdht_pkg::Q_W-1:0] py);
        t_wide cx, cy, x1, y1, x2, y2;
        t_wide ddx, ddy, den, cross_dd, cterm, num_x, num_y;
        cx       = $signed(r.cx);
        cy       = $signed(r.cy);
        x1       = $signed(r.nx);
        y1       = $signed(r.ny);
        x2       = $signed(r.fx);
        y2       = $signed(r.fy);
        ddx      = x1 - x2;
        ddy      = y1 - y2;
        cross_dd = x1 * y2 - y1 * x2;
        if (diag == RISING) begin
            den   = ddy - ddx;
            cterm = cx - cy;
        end else begin
            den   = ddx + ddy;
            cterm = -(cx + cy);
        end
        if (den == 0) begin
            px = '0;
            py = '0;
            return 1'b0;
        end
        num_x = -cross_dd - ddx * cterm * Q_ONE;
        num_y = ((diag == RISING) ? -cross_dd : cross_dd) - ddy * cterm * Q_ONE;
        px = sat_quotient(num_x, den);
        py = sat_quotient(num_y, den);
        return (px > cx * Q_ONE - rbdht_pkg::Q_HALF) && (px < cx * Q_ONE + rbdht_pkg::Q_HALF) &&
               (py > cy * Q_ONE - rbdht_pkg::Q_HALF) && (py < cy * Q_ONE + rbdht_pkg::Q_HALF);
    endfunction

    function automatic t_cell_hit predict_cell_hit(input t_ray r);
        t_cell_hit                        res;
        logic signed [rbdht_pkg::Q_W-1:0] px;
        logic signed [rbdht_pkg::Q_W-1:0] py;
        res.hit = try_diagonal(RISING, r, px, py);
        if (!res.hit)
            res.hit = try_diagonal(FALLING, r, px, py);
        res.x = px;
        res.y = py;
        return res;
    endfunction

    function automatic t_ray mk_ray(input int cx, input int cy,
                                    input logic signed [rbdht_pkg::Q_W-1:0] nx, ny, fx, fy);
        t_ray r;
        r.cx = cx[rbdht_pkg::CELL_W-1:0];
        r.cy = cy[rbdht_pkg::CELL_W-1:0];
        r.nx = nx;
        r.ny = ny;
        r.fx = fx;
        r.fy = fy;
        return r;
    endfunction

    // start stays high across back-to-back requests; in this task only the idle loop lowers it.
    task automatic send_ray(input t_ray r);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start     <= 1'b1;
        i_cell_x  <= r.cx;
        i_cell_y  <= r.cy;
        i_near_px <= r.nx;
        i_near_py <= r.ny;
        i_far_px  <= r.fx;
        i_far_py  <= r.fy;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        diagonal_hit_q.push_back(predict_cell_hit(r));
    endtask

    always @(posedge i_clk) begin
        t_cell_hit want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (diagonal_hit_q.size() == 0) begin
                $error("o_valid with no request pending");
                mismatch_count++;
            end else begin
                want = diagonal_hit_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("o_hit: expected %0d, got %0d", want.hit, o_hit);
                    mismatch_count++;
                end
                if (o_hit_x !== want.x) begin
                    $error("o_hit_x: expected %0d, got %0d", want.x, o_hit_x);
                    mismatch_count++;
                end
                if (o_hit_y !== want.y) begin
                    $error("o_hit_y: expected %0d, got %0d", want.y, o_hit_y);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_parallel_rays();
        send_ray(mk_ray(0, 0, 0, 0, 0, 0));
        send_ray(mk_ray(3, -2, 12345, -67890, 12345, -67890));
        // parallel to rising, crosses falling inside the cell
        send_ray(mk_ray(0, 0, -131072, -114688, 131072, 147456));
        // parallel to falling, rising point outside
        send_ray(mk_ray(0, 0, 0, 5 * Q_ONE, Q_ONE, 4 * Q_ONE));
    endtask

    task automatic test_diagonal_hits();
        send_ray(mk_ray(0, 0, -131072, 16384, 131072, 16384));
        send_ray(mk_ray(0, 0, -19661, -131072, -19661, 131072));
        send_ray(mk_ray(100, -200, 98 * Q_ONE, -200 * Q_ONE - 16384,
                        103 * Q_ONE, -200 * Q_ONE - 16384));
        send_ray(mk_ray(0, 0, -131072, 5 * Q_ONE, 131072, 5 * Q_ONE));
    endtask

    // points exactly on and one LSB inside the cell boundary
    task automatic test_cell_edges();
        send_ray(mk_ray(0, 0, -131072, rbdht_pkg::Q_HALF, 131072, rbdht_pkg::Q_HALF));
        send_ray(mk_ray(0, 0, -131072, rbdht_pkg::Q_HALF - 1, 131072, rbdht_pkg::Q_HALF - 1));
        send_ray(mk_ray(0, 0, -rbdht_pkg::Q_HALF, -131072, -rbdht_pkg::Q_HALF, 131072));
        send_ray(mk_ray(0, 0, -rbdht_pkg::Q_HALF + 1, -131072,
                        -rbdht_pkg::Q_HALF + 1, 131072));
    endtask

    task automatic test_rounding();
        send_ray(mk_ray(0, 0, 0, Q_ONE, 3 * Q_ONE, 7));
        send_ray(mk_ray(0, 0, 0, -Q_ONE, -3 * Q_ONE, -7));
    endtask

    task automatic test_saturation();
        send_ray(mk_ray(0, 0, 0, Q_ONE, 32'sh7FFF_0000, rbdht_pkg::Q_MAX));
        send_ray(mk_ray(0, 0, 0, -Q_ONE, -32'sh7FFF_0000, -32'sh7FFF_FFFF));
        send_ray(mk_ray(5, -9, rbdht_pkg::Q_MAX, rbdht_pkg::Q_MIN + 1,
                        rbdht_pkg::Q_MIN, rbdht_pkg::Q_MAX));
    endtask

    task automatic test_field_extremes();
        send_ray(mk_ray(16383, 16383, 16381 * Q_ONE, 16383 * Q_ONE + 16384,
                        16385 * Q_ONE, 16383 * Q_ONE + 16384));
        send_ray(mk_ray(-16384, -16384, -16386 * Q_ONE, -16384 * Q_ONE + 16384,
                        -16382 * Q_ONE, -16384 * Q_ONE + 16384));
        send_ray(mk_ray(-16384, 16383, rbdht_pkg::Q_MAX, rbdht_pkg::Q_MIN,
                        rbdht_pkg::Q_MIN, rbdht_pkg::Q_MAX));
        send_ray(mk_ray(16383, -16384, rbdht_pkg::Q_MIN, rbdht_pkg::Q_MIN,
                        rbdht_pkg::Q_MAX, rbdht_pkg::Q_MAX));
        send_ray(mk_ray(-16384, -16384, rbdht_pkg::Q_MIN, rbdht_pkg::Q_MAX,
                        rbdht_pkg::Q_MAX, rbdht_pkg::Q_MAX));
        send_ray(mk_ray(16383, 16383, rbdht_pkg::Q_MAX, rbdht_pkg::Q_MAX,
                        rbdht_pkg::Q_MIN, rbdht_pkg::Q_MAX));
        send_ray(mk_ray(-1, -1, rbdht_pkg::Q_MIN, rbdht_pkg::Q_MIN, -1, -1));
    endtask

    task automatic test_random_rays(input int pct, input int count);
        t_ray                             r;
        int                               pick;
        int                               cx, cy;
        logic signed [rbdht_pkg::Q_W-1:0] tx, ty, dx, dy;
        logic [31:0]                      bits;
        idle_pct = pct;
        repeat (count) begin
            pick = $urandom_range(99);
            if ($urandom_range(9) < 7) begin
                cx = int'($urandom_range(127)) - 64;
                cy = int'($urandom_range(127)) - 64;
            end else begin
                cx = int'($urandom_range(32767)) - 16384;
                cy = int'($urandom_range(32767)) - 16384;
            end
            tx = cx * Q_ONE + int'($urandom_range(98304)) - 49152;
            ty = cy * Q_ONE + int'($urandom_range(98304)) - 49152;
            dx = int'($urandom_range(524288)) - 262144;
            dy = int'($urandom_range(524288)) - 262144;
            if (pick < 45) begin
                // general crossing through or near the cell
            end else if (pick < 60) begin
                // nearly parallel to a diagonal: large quotients
                dx = int'($urandom_range(2097152)) - 1048576;
                dy = ($urandom_range(1) ? dx : -dx) + int'($urandom_range(6)) - 3;
            end else if (pick < 70) begin
                if ($urandom_range(3) == 0) begin
                    dx = '0;
                    dy = '0;
                end else begin
                    dy = $urandom_range(1) ? dx : -dx;
                end
            end else if (pick < 85) begin
                bits = $urandom();
                cx   = int'(bits[rbdht_pkg::CELL_W-1:0]);
                bits = $urandom();
                cy   = int'(bits[rbdht_pkg::CELL_W-1:0]);
                tx   = $urandom();
                ty   = $urandom();
                dx   = $urandom();
                dy   = $urandom();
            end else begin
                if ($urandom_range(1))
                    dy = int'($urandom_range(8)) - 4;
                else
                    dx = int'($urandom_range(8)) - 4;
            end
            r = mk_ray(cx, cy, tx - dx, ty - dy, tx + dx, ty + dy);
            send_ray(r);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 25;
        test_parallel_rays();
        test_diagonal_hits();
        test_cell_edges();
        test_rounding();
        test_saturation();
        test_field_extremes();
        test_random_rays(25, 567);
        test_random_rays(84, 567);
        test_random_rays(0, 566);
        start <= 1'b0;
        while (diagonal_hit_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
